>>> rtl/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the bounded stack with top-down search.
// ----------------------------------------------------------------------------
package bss_pkg;

	// fixed field widths
	localparam int DATA_W    = 32;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int CAP_W     = 7;

	// default storage depth and capacity register reset value
	localparam int DEPTH_DEF = 64;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH   = 3'd0,
		MODE_POP    = 3'd1,
		MODE_PEEK   = 3'd2,
		MODE_CLEAR  = 3'd3,
		MODE_SEARCH = 3'd4
	} mode_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_SCAN = 2'd2,
		ST_DONE = 2'd3
	} state_t;

endpackage

>>> rtl/bounded_stack_with_search_core.sv
// ----------------------------------------------------------------------------
// bounded_stack_with_search_core
// Bounded LIFO stack of 32-bit words with push, pop, peek, clear and a
// top-down search; every transaction returns status, count and flags.
// ----------------------------------------------------------------------------
// Sequence: push, clear and unused modes pass from idle to done; pop and peek
//   go through a read state; search compares entries top down, one per cycle,
//   through the single read port of the word store.
// Throughput: one transaction at a time; the next is taken once the result
//   sits in the output register, which may still be waiting to be taken.
// Reset: count cleared, capacity set to 64; stored words undefined, no sweep.
module bounded_stack_with_search_core
	import bss_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [MODE_W-1:0]        mode,
	input  logic signed [DATA_W-1:0] value,
	// response channel
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [STATUS_W-1:0]      status,
	output logic signed [DATA_W-1:0] data,
	output logic [AW-1:0]            found_index,
	output logic [CW-1:0]            entry_count,
	output logic                     is_empty,
	output logic                     is_full,
	// configuration channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CAP_W-1:0]         cfg_data
);

	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	state_t              state_q, state_d;
	logic [CAP_W-1:0]    cap_q;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic [MODE_W-1:0]   mode_q;
	logic [DATA_W-1:0]   key_q;
	status_t             res_status_q, res_status_d;
	logic [DATA_W-1:0]   res_data_q, res_data_d;
	logic [AW-1:0]       res_fidx_q, res_fidx_d;
	logic                res_set;
	logic                rsp_valid_q;
	logic                out_load;

	logic                req_take;
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;
	logic [CW-1:0]       cnt_m1;
	logic [AW-1:0]       top_addr;
	logic [AW-1:0]       idx_m1;
	logic [LW-1:0]       cap_ext, dep_ext, lim, cnt_ext;
	logic                full_now;
	logic                cnt_zero;

	// effective limit and flags
	always_comb begin
		cap_ext  = LW'(cap_q);
		dep_ext  = LW'(DEPTH);
		lim      = (cap_ext > dep_ext) ? dep_ext : cap_ext;
		cnt_ext  = LW'(count_q);
		full_now = (cnt_ext >= lim);
		cnt_zero = (count_q == '0);
		cnt_m1   = count_q - CW'(1);
		top_addr = cnt_m1[AW-1:0];
		idx_m1   = idx_q - AW'(1);
	end

	assign req_take  = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// word store
	bss_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and datapath controls
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_raddr    = top_addr;
		res_set      = 1'b0;
		res_status_d = STAT_OK;
		res_data_d   = '0;
		res_fidx_d   = '0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					unique case (mode)
						MODE_PUSH: begin
							res_set = 1'b1;
							if (full_now) begin
								res_status_d = STAT_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
							end
							state_d = ST_DONE;
						end
						MODE_POP, MODE_PEEK: begin
							if (cnt_zero) begin
								res_set      = 1'b1;
								res_status_d = STAT_EMPTY;
								state_d      = ST_DONE;
							end else begin
								ram_re  = 1'b1;
								state_d = ST_READ;
							end
						end
						MODE_CLEAR: begin
							res_set = 1'b1;
							count_d = '0;
							state_d = ST_DONE;
						end
						MODE_SEARCH: begin
							if (cnt_zero) begin
								res_set      = 1'b1;
								res_status_d = STAT_NOTFOUND;
								state_d      = ST_DONE;
							end else begin
								ram_re  = 1'b1;
								idx_d   = top_addr;
								state_d = ST_SCAN;
							end
						end
						default: begin
							res_set = 1'b1;
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_READ: begin
				res_set    = 1'b1;
				res_data_d = ram_rdata;
				if (mode_q == MODE_POP) begin
					count_d = cnt_m1;
				end
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				// compare the entry at idx_q, walk down on a miss
				if (ram_rdata == key_q) begin
					res_set    = 1'b1;
					res_fidx_d = idx_q;
					state_d    = ST_DONE;
				end else if (idx_q == '0) begin
					res_set      = 1'b1;
					res_status_d = STAT_NOTFOUND;
					state_d      = ST_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = idx_m1;
					idx_d     = idx_m1;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// transaction payload and pending result
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (req_take) begin
			mode_q <= mode;
			key_q  <= value;
		end
		if (res_set) begin
			res_status_q <= res_status_d;
			res_data_q   <= res_data_d;
			res_fidx_q   <= res_fidx_d;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			status      <= res_status_q;
			data        <= res_data_q;
			found_index <= res_fidx_q;
			entry_count <= count_q;
			is_empty    <= cnt_zero;
			is_full     <= full_now;
		end
	end

	assign rsp_valid = rsp_valid_q;

	// checks
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (mode == MODE_PUSH) && !full_now |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (mode == MODE_CLEAR) |=> count_q == '0)
		else $error("clear left entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count beyond storage depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CW'(idx_q) < count_q))
		else $error("search index outside held entries");

endmodule

>>> rtl/bss_ram.sv
// ----------------------------------------------------------------------------
// bss_ram
// Stack word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bss_ram
	import bss_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> bench/tb_bounded_stack_with_search_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_stack_with_search_core
// Self-checking bench for the bounded stack with top-down search. A directed
// pass covers empty and full stacks, word extremes, unused modes and capacity
// edge cases. Random phases follow with varied capacity and handshake idling.
// A scoreboard predicts every result as each request is accepted.
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_search_core;
	import bss_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES    = 100;

	// one predicted response
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   data;
		logic [5:0]          found_index;
		logic [CAP_W-1:0]    entry_count;
		logic                is_empty;
		logic                is_full;
	} stack_result_t;

	// shadow stack and queue of predicted responses
	class stack_scoreboard;
		logic [DATA_W-1:0] words [DEPTH_DEF];
		int unsigned       count;
		logic [CAP_W-1:0]  capacity;
		stack_result_t     expected_q [$];
		int unsigned       errors;

		function new();
			count    = 0;
			capacity = CAP_RESET;
			errors   = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			capacity = c;
		endfunction

		function int unsigned limit();
			return (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// a word currently held (a random word when empty), so that searches can hit
		function logic [DATA_W-1:0] stored_word();
			if (count == 0)
				return $urandom;
			return words[$urandom_range(count - 1, 0)];
		endfunction

		// predict the response of an accepted request transaction
		function void note_request(logic [MODE_W-1:0] m, logic [DATA_W-1:0] v);
			stack_result_t r;
			int unsigned   lim;
			int unsigned   i;
			bit            hit;
			r   = '0;
			lim = limit();
			hit = 1'b0;
			case (m)
				MODE_PUSH: begin
					if (count >= lim)
						r.status = STAT_FULL;
					else begin
						words[count] = v;
						count++;
					end
				end
				MODE_POP, MODE_PEEK: begin
					if (count == 0)
						r.status = STAT_EMPTY;
					else begin
						r.data = words[count - 1];
						if (m == MODE_POP)
							count--;
					end
				end
				MODE_CLEAR: begin
					count = 0;
				end
				MODE_SEARCH: begin
					// walk from the top down, stop at the first match
					for (i = count; i > 0 && !hit; i--) begin
						if (words[i - 1] == v) begin
							hit = 1'b1;
							r.found_index = 6'(i - 1);
						end
					end
					if (!hit)
						r.status = STAT_NOTFOUND;
				end
				default: ;
			endcase
			r.entry_count = CAP_W'(count);
			r.is_empty    = (count == 0);
			r.is_full     = (count >= lim);
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] e, logic [DATA_W-1:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
				errors++;
			end
		endfunction

		// compare an accepted response transaction with the oldest prediction
		function void check_response(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] d,
				logic [5:0] fi, logic [CAP_W-1:0] cnt, logic emp, logic ful);
			stack_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: response with none expected, expected none, actual status %0h",
					$time, st);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare_field("status", DATA_W'(e.status), DATA_W'(st));
			compare_field("data", e.data, d);
			compare_field("found_index", DATA_W'(e.found_index), DATA_W'(fi));
			compare_field("entry_count", DATA_W'(e.entry_count), DATA_W'(cnt));
			compare_field("is_empty", DATA_W'(e.is_empty), DATA_W'(emp));
			compare_field("is_full", DATA_W'(e.is_full), DATA_W'(ful));
		endfunction
	endclass

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     req_valid   = 1'b0;
	logic                     req_stall;
	logic [MODE_W-1:0]        mode        = MODE_PUSH;
	logic signed [DATA_W-1:0] value       = '0;
	logic                     rsp_valid;
	logic                     rsp_stall   = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] data;
	logic [5:0]               found_index;
	logic [CAP_W-1:0]         entry_count;
	logic                     is_empty;
	logic                     is_full;
	logic                     cfg_valid   = 1'b0;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         cfg_data    = '0;

	stack_scoreboard sb;
	int unsigned     send_idle_pct = 0;
	int unsigned     rsp_stall_pct = 0;
	int unsigned     holds_asked   = 0;
	int unsigned     holds_served  = 0;
	int unsigned     hold_left     = 0;

	bounded_stack_with_search_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.mode        (mode),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.data        (data),
		.found_index (found_index),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// run guard
	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// response side: random stalls, plus a long counted hold on request
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served = holds_asked;
			hold_left    = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else
			rsp_stall <= ($urandom_range(99, 0) < rsp_stall_pct);
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(status, data, found_index, entry_count, is_empty, is_full);
	end

	// offer one request transaction and wait until it is taken
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		mode      <= m;
		value     <= v;
		do @(posedge clk); while (req_stall);
		sb.note_request(m, v);
	endtask

	// drop valid and wait for every predicted response
	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_capacity(c);
	endtask

	// words biased towards small values and extremes so that searches hit
	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(3, 0))
			0: return $urandom_range(7, 0);
			1: return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_item();
		int unsigned       r;
		logic [DATA_W-1:0] w;
		r = $urandom_range(99, 0);
		if (r < 40)
			send_item(MODE_PUSH, pick_word());
		else if (r < 55)
			send_item(MODE_POP, $urandom);
		else if (r < 62)
			send_item(MODE_PEEK, $urandom);
		else if (r < 80) begin
			w = $urandom_range(1, 0) ? sb.stored_word() : pick_word();
			send_item(MODE_SEARCH, w);
		end else if (r < 83)
			send_item(MODE_CLEAR, $urandom);
		else if (r < 86)
			send_item(MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO)), $urandom);
		else
			send_item(MODE_PUSH, $urandom);
	endtask

	// one random phase: capacity, idling, optional fill burst and long hold
	task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned s_pct,
			input int unsigned r_pct, input int unsigned fill_n, input int unsigned n,
			input bit with_hold);
		write_capacity(cap);
		send_idle_pct = s_pct;
		rsp_stall_pct = r_pct;
		repeat (fill_n) send_item(MODE_PUSH, $urandom);
		if (with_hold)
			holds_asked++;
		repeat (n) random_item();
	endtask

	initial begin
		int u;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack and unused modes
		send_item(MODE_POP, 32'h0);
		send_item(MODE_PEEK, 32'hdead_beef);
		send_item(MODE_SEARCH, 32'h0);
		for (u = MODE_UNUSED_LO; u <= MODE_UNUSED_HI; u++)
			send_item(MODE_W'(u), 32'hffff_ffff);

		// word extremes, duplicate words, topmost match
		send_item(MODE_PUSH, 32'h7fff_ffff);
		send_item(MODE_PUSH, 32'h8000_0000);
		send_item(MODE_PUSH, 32'h0);
		send_item(MODE_PUSH, 32'hffff_ffff);
		send_item(MODE_PUSH, 32'hffff_ffff);
		send_item(MODE_SEARCH, 32'hffff_ffff);
		send_item(MODE_SEARCH, 32'h8000_0000);
		send_item(MODE_SEARCH, 32'h1234_5678);
		send_item(MODE_PEEK, 32'h0);
		send_item(MODE_POP, 32'h0);
		send_item(MODE_CLEAR, 32'h0);
		send_item(MODE_POP, 32'h0);
		send_item(MODE_PUSH, 32'h1);
		send_item(MODE_PUSH, 32'h2);
		send_item(MODE_PUSH, 32'h3);

		// capacity lowered below the count keeps the entries
		write_capacity(7'd2);
		send_item(MODE_PUSH, 32'h4);
		send_item(MODE_POP, 32'h0);
		send_item(MODE_SEARCH, 32'h1);

		// zero capacity: always full
		write_capacity(7'd0);
		send_item(MODE_PUSH, 32'h5);
		send_item(MODE_CLEAR, 32'h0);
		send_item(MODE_PUSH, 32'h6);

		// random phases; capacity above the depth saturates
		run_phase(7'd127, 0, 0, 66, 60, 1'b0);
		run_phase(7'd3, 78, 0, 0, 70, 1'b0);
		run_phase(7'd64, 0, 78, 0, 80, 1'b1);
		run_phase(7'd1, 21, 21, 0, 70, 1'b0);
		run_phase(7'd0, 0, 0, 0, 20, 1'b0);
		run_phase(7'd40, 78, 0, 0, 80, 1'b0);

		// drain and let any stray response show up
		rsp_stall_pct = 0;
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
